// ===== rtl/y2r565_pkg.sv =====
// Package for the 2x2 block YUV 4:2:0 to RGB565 converter.
// Holds payload types, chroma coefficient tables and the channel clamp.
// No dependencies.
package y2r565_pkg;

  typedef struct packed {
    logic [7:0] luma_top_left;
    logic [7:0] luma_top_right;
    logic [7:0] luma_bottom_left;
    logic [7:0] luma_bottom_right;
    logic [7:0] chroma_blue_diff;
    logic [7:0] chroma_red_diff;
  } blk_t;

  typedef struct packed {
    logic [31:0] top_pixel_pair;
    logic [31:0] bottom_pixel_pair;
  } pix_t;

  typedef struct packed {
    logic signed [8:0] blue;
    logic signed [8:0] green;
    logic signed [8:0] red;
  } chroma_terms_t;

  localparam int unsigned MagMax   = 128;
  localparam int unsigned BlueNum  = 1772;
  localparam int unsigned BlueDen  = 1000;
  localparam int unsigned GreenUNum = 34414;
  localparam int unsigned GreenVNum = 71414;
  localparam int unsigned GreenDen = 100000;
  localparam int unsigned RedNum   = 1402;
  localparam int unsigned RedDen   = 1000;
  localparam logic [7:0]  ChromaMid = 8'd128;

  typedef logic [7:0] term_tab_t [0:MagMax];

  function automatic term_tab_t build_blue_tab();
    term_tab_t t;
    for (int i = 0; i <= MagMax; i++) begin
      t[i] = 8'((i * BlueNum) / BlueDen);
    end
    return t;
  endfunction

  function automatic term_tab_t build_green_u_tab();
    term_tab_t t;
    for (int i = 0; i <= MagMax; i++) begin
      t[i] = 8'((i * GreenUNum) / GreenDen);
    end
    return t;
  endfunction

  function automatic term_tab_t build_green_v_tab();
    term_tab_t t;
    for (int i = 0; i <= MagMax; i++) begin
      t[i] = 8'((i * GreenVNum) / GreenDen);
    end
    return t;
  endfunction

  function automatic term_tab_t build_red_tab();
    term_tab_t t;
    for (int i = 0; i <= MagMax; i++) begin
      t[i] = 8'((i * RedNum) / RedDen);
    end
    return t;
  endfunction

  localparam term_tab_t BlueTab   = build_blue_tab();
  localparam term_tab_t GreenUTab = build_green_u_tab();
  localparam term_tab_t GreenVTab = build_green_v_tab();
  localparam term_tab_t RedTab    = build_red_tab();

  function automatic logic [7:0] clamp8(input logic signed [10:0] x);
    logic [7:0] r;
    if (x[10]) begin
      r = 8'd0;
    end else if (|x[9:8]) begin
      r = 8'hFF;
    end else begin
      r = x[7:0];
    end
    return r;
  endfunction

endpackage

// ===== rtl/y2r565_chroma.sv =====
// Chroma term unit: centers U and V and looks up the signed blue, green and red terms.
// Depends on y2r565_pkg for the coefficient tables and the term struct.
module y2r565_chroma (
  input  logic [7:0]                   chroma_blue_diff,
  input  logic [7:0]                   chroma_red_diff,
  output y2r565_pkg::chroma_terms_t    terms
);
  import y2r565_pkg::*;

  logic              u_neg;
  logic              v_neg;
  logic [7:0]        u_mag;
  logic [7:0]        v_mag;
  logic signed [8:0] blue_s;
  logic signed [8:0] gu_s;
  logic signed [8:0] gv_s;
  logic signed [8:0] red_s;

  assign u_neg = ~chroma_blue_diff[7];
  assign v_neg = ~chroma_red_diff[7];
  assign u_mag = u_neg ? 8'(ChromaMid - chroma_blue_diff) : {1'b0, chroma_blue_diff[6:0]};
  assign v_mag = v_neg ? 8'(ChromaMid - chroma_red_diff) : {1'b0, chroma_red_diff[6:0]};

  always_comb begin
    blue_s = $signed({1'b0, BlueTab[u_mag]});
    gu_s   = $signed({1'b0, GreenUTab[u_mag]});
    gv_s   = $signed({1'b0, GreenVTab[v_mag]});
    red_s  = $signed({1'b0, RedTab[v_mag]});
    terms.blue  = u_neg ? -blue_s : blue_s;
    terms.red   = v_neg ? -red_s : red_s;
    terms.green = (u_neg ? -gu_s : gu_s) + (v_neg ? -gv_s : gv_s);
  end

endmodule

// ===== rtl/y2r565_lane.sv =====
// Pixel lane: adds the blue and red terms to one luma sample, subtracts the green term, clamps and packs RGB565.
// Depends on y2r565_pkg for the term struct and the clamp.
module y2r565_lane (
  input  logic [7:0]                luma,
  input  y2r565_pkg::chroma_terms_t terms,
  output logic [15:0]               rgb
);
  import y2r565_pkg::*;

  logic signed [10:0] y_s;
  logic signed [10:0] b_sum;
  logic signed [10:0] g_sum;
  logic signed [10:0] r_sum;
  logic [7:0]         b;
  logic [7:0]         g;
  logic [7:0]         r;

  always_comb begin
    y_s   = $signed({3'b000, luma});
    b_sum = y_s + $signed({{2{terms.blue[8]}}, terms.blue});
    g_sum = y_s - $signed({{2{terms.green[8]}}, terms.green});
    r_sum = y_s + $signed({{2{terms.red[8]}}, terms.red});
    b     = clamp8(b_sum);
    g     = clamp8(g_sum);
    r     = clamp8(r_sum);
    rgb   = {r[7:3], g[7:2], b[7:3]};
  end

endmodule

// ===== rtl/yuv420_to_rgb565_block_converter.sv =====
// Top level of the 2x2 block YUV 4:2:0 to RGB565 converter.
// Uses y2r565_pkg, y2r565_chroma and four y2r565_lane instances.
//
//   channel | handshake             | payload
//   --------+-----------------------+-------------------------------
//   blk     | blk_valid, blk_ready  | blk (four Y, one U, one V)
//   pix     | pix_valid, pix_ready  | pix (top and bottom pixel pairs)
//
// One item per clock while pix_ready does not stall; a result passes stage one, then the output register.
// Stage one holds the chroma terms and lumas, stage two is the output register.
// Each stage takes a new item when empty or when it passes its item on, so an
// empty stage one still accepts while a result waits on pix_ready.
// rst clears both stage valid bits.
module yuv420_to_rgb565_block_converter (
  input  logic              clk,
  input  logic              rst,
  input  logic              blk_valid,
  output logic              blk_ready,
  input  y2r565_pkg::blk_t  blk,
  output logic              pix_valid,
  input  logic              pix_ready,
  output y2r565_pkg::pix_t  pix
);
  import y2r565_pkg::*;

  chroma_terms_t terms_next;
  chroma_terms_t terms;
  logic [7:0]    luma_tl;
  logic [7:0]    luma_tr;
  logic [7:0]    luma_bl;
  logic [7:0]    luma_br;
  logic          s1_valid;
  logic          s1_ready;
  logic          out_en;
  logic [15:0]   rgb_tl;
  logic [15:0]   rgb_tr;
  logic [15:0]   rgb_bl;
  logic [15:0]   rgb_br;
  pix_t          pix_next;

  assign out_en    = ~pix_valid | pix_ready;
  assign s1_ready  = ~s1_valid | out_en;
  assign blk_ready = s1_ready;

  y2r565_chroma u_chroma (
    .chroma_blue_diff (blk.chroma_blue_diff),
    .chroma_red_diff  (blk.chroma_red_diff),
    .terms            (terms_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_ready) begin
      s1_valid <= blk_valid;
    end
    if (s1_ready && blk_valid) begin
      terms   <= terms_next;
      luma_tl <= blk.luma_top_left;
      luma_tr <= blk.luma_top_right;
      luma_bl <= blk.luma_bottom_left;
      luma_br <= blk.luma_bottom_right;
    end
  end

  y2r565_lane u_lane_tl (.luma(luma_tl), .terms(terms), .rgb(rgb_tl));
  y2r565_lane u_lane_tr (.luma(luma_tr), .terms(terms), .rgb(rgb_tr));
  y2r565_lane u_lane_bl (.luma(luma_bl), .terms(terms), .rgb(rgb_bl));
  y2r565_lane u_lane_br (.luma(luma_br), .terms(terms), .rgb(rgb_br));

  always_comb begin
    pix_next.top_pixel_pair    = {rgb_tr, rgb_tl};
    pix_next.bottom_pixel_pair = {rgb_br, rgb_bl};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pix_valid <= 1'b0;
    end else if (out_en) begin
      pix_valid <= s1_valid;
    end
    if (out_en && s1_valid) begin
      pix <= pix_next;
    end
  end

endmodule

// ===== tb/rgb565_pair_checker.sv =====
`timescale 1ns / 1ps
// Scoreboard for the YUV 4:2:0 to RGB565 block converter. It watches both channels,
// predicts the pixel pair item for each accepted block and compares the results.
// Depends on the y2r565_pkg payload types.
module rgb565_pair_checker (
  input  logic             clk,
  input  logic             rst,
  input  logic             blk_valid,
  input  logic             blk_ready,
  input  y2r565_pkg::blk_t blk,
  input  logic             pix_valid,
  input  logic             pix_ready,
  input  y2r565_pkg::pix_t pix,
  output int               pending,
  output int               failures
);
  import y2r565_pkg::*;

  localparam int ChromaCenter = 128;
  localparam int BlueMul      = 1772;
  localparam int BlueDiv      = 1000;
  localparam int GreenUMul    = 34414;
  localparam int GreenVMul    = 71414;
  localparam int GreenDiv     = 100000;
  localparam int RedMul       = 1402;
  localparam int RedDiv       = 1000;
  localparam int ByteMax      = 255;

  pix_t expected_pairs[$];
  pix_t want;

  function automatic int chroma_term(input int diff, input int num, input int den);
    int q;
    q = ((diff < 0 ? -diff : diff) * num) / den;
    return (diff < 0) ? -q : q;
  endfunction

  function automatic logic [7:0] saturate(input int x);
    if (x < 0) begin
      return 8'd0;
    end
    if (x > ByteMax) begin
      return 8'hFF;
    end
    return x[7:0];
  endfunction

  function automatic logic [15:0] rgb565(input int luma, input int blue_t, input int green_u,
                                         input int green_v, input int red_t);
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
    b = saturate(luma + blue_t);
    g = saturate(luma - green_u - green_v);
    r = saturate(luma + red_t);
    return {r[7:3], g[7:2], b[7:3]};
  endfunction

  function automatic pix_t convert_block(input blk_t b);
    int   du;
    int   dv;
    int   bt;
    int   gu;
    int   gv;
    int   rt;
    pix_t p;
    du = int'(b.chroma_blue_diff) - ChromaCenter;
    dv = int'(b.chroma_red_diff) - ChromaCenter;
    bt = chroma_term(du, BlueMul, BlueDiv);
    gu = chroma_term(du, GreenUMul, GreenDiv);
    gv = chroma_term(dv, GreenVMul, GreenDiv);
    rt = chroma_term(dv, RedMul, RedDiv);
    p.top_pixel_pair = {rgb565(int'(b.luma_top_right), bt, gu, gv, rt),
                        rgb565(int'(b.luma_top_left), bt, gu, gv, rt)};
    p.bottom_pixel_pair = {rgb565(int'(b.luma_bottom_right), bt, gu, gv, rt),
                           rgb565(int'(b.luma_bottom_left), bt, gu, gv, rt)};
    return p;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      expected_pairs.delete();
      pending <= 0;
    end else begin
      if (pix_valid && pix_ready) begin
        if (expected_pairs.size() == 0) begin
          $error("pix item with no block pending: %h", pix);
          failures++;
        end else begin
          want = expected_pairs.pop_front();
          if (pix.top_pixel_pair !== want.top_pixel_pair) begin
            $error("top_pixel_pair: expected %h, got %h",
                   want.top_pixel_pair, pix.top_pixel_pair);
            failures++;
          end
          if (pix.bottom_pixel_pair !== want.bottom_pixel_pair) begin
            $error("bottom_pixel_pair: expected %h, got %h",
                   want.bottom_pixel_pair, pix.bottom_pixel_pair);
            failures++;
          end
        end
      end
      if (blk_valid && blk_ready) begin
        expected_pairs.push_back(convert_block(blk));
      end
      pending <= expected_pairs.size();
    end
  end

endmodule

// ===== tb/yuv420_to_rgb565_block_converter_test.sv =====
`timescale 1ns / 1ps
// Top of the testbench for yuv420_to_rgb565_block_converter: drives directed and
// random 2x2 blocks under several idle mixes and gives the verdict.
// Depends on y2r565_pkg, the converter RTL and rgb565_pair_checker.
module yuv420_to_rgb565_block_converter_test;
  import y2r565_pkg::*;

  localparam int BlocksPerPhase = 440;

  logic clk = 1'b0;
  logic rst;
  logic blk_valid;
  logic blk_ready;
  blk_t blk;
  logic pix_valid;
  logic pix_ready;
  pix_t pix;
  int   pending;
  int   failures;
  int   src_idle_pct;
  int   sink_stall_pct;

  yuv420_to_rgb565_block_converter uut (
    .clk(clk),
    .rst(rst),
    .blk_valid(blk_valid),
    .blk_ready(blk_ready),
    .blk(blk),
    .pix_valid(pix_valid),
    .pix_ready(pix_ready),
    .pix(pix)
  );

  rgb565_pair_checker u_checker (
    .clk(clk),
    .rst(rst),
    .blk_valid(blk_valid),
    .blk_ready(blk_ready),
    .blk(blk),
    .pix_valid(pix_valid),
    .pix_ready(pix_ready),
    .pix(pix),
    .pending(pending),
    .failures(failures)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    pix_ready <= ($urandom_range(99) >= sink_stall_pct);
  end

  function automatic blk_t make_block(input logic [7:0] ytl, input logic [7:0] ytr,
                                      input logic [7:0] ybl, input logic [7:0] ybr,
                                      input logic [7:0] u, input logic [7:0] v);
    blk_t b;
    b.luma_top_left     = ytl;
    b.luma_top_right    = ytr;
    b.luma_bottom_left  = ybl;
    b.luma_bottom_right = ybr;
    b.chroma_blue_diff  = u;
    b.chroma_red_diff   = v;
    return b;
  endfunction

  function automatic logic [7:0] pick_sample();
    logic [7:0] corners [7];
    corners = '{8'd0, 8'd1, 8'd127, 8'd128, 8'd129, 8'd254, 8'd255};
    if ($urandom_range(3) == 0) begin
      return corners[$urandom_range(6)];
    end
    return 8'($urandom_range(255));
  endfunction

  task automatic send_block(input blk_t b);
    if ($urandom_range(99) < src_idle_pct) begin
      blk_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < src_idle_pct);
    end
    blk_valid <= 1'b1;
    blk <= b;
    do @(posedge clk); while (!blk_ready);
  endtask

  task automatic drain();
    blk_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic run_phase(input int idle_pct, input int stall_pct);
    src_idle_pct = idle_pct;
    sink_stall_pct <= stall_pct;
    for (int i = 0; i < BlocksPerPhase; i++) begin
      send_block(make_block(pick_sample(), pick_sample(), pick_sample(), pick_sample(),
                            pick_sample(), pick_sample()));
    end
    drain();
  endtask

  initial begin
    rst = 1'b1;
    blk_valid = 1'b0;
    blk = '0;
    pix_ready = 1'b0;
    src_idle_pct = 0;
    sink_stall_pct = 0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    send_block(make_block(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
    send_block(make_block(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
    send_block(make_block(8'h00, 8'hFF, 8'h80, 8'h7F, 8'h80, 8'h80));
    send_block(make_block(8'h10, 8'h50, 8'h90, 8'hD0, 8'h80, 8'h80));
    send_block(make_block(8'h00, 8'h01, 8'hFE, 8'hFF, 8'h00, 8'h80));
    send_block(make_block(8'h00, 8'h01, 8'hFE, 8'hFF, 8'hFF, 8'h80));
    send_block(make_block(8'h00, 8'h01, 8'hFE, 8'hFF, 8'h80, 8'h00));
    send_block(make_block(8'h00, 8'h01, 8'hFE, 8'hFF, 8'h80, 8'hFF));
    send_block(make_block(8'hFF, 8'h00, 8'hFF, 8'h00, 8'h00, 8'h00));
    send_block(make_block(8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF, 8'hFF));
    send_block(make_block(8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF));
    send_block(make_block(8'h00, 8'hFF, 8'h00, 8'hFF, 8'hFF, 8'h00));
    send_block(make_block(8'h80, 8'h80, 8'h80, 8'h80, 8'h7F, 8'h81));
    send_block(make_block(8'h80, 8'h80, 8'h80, 8'h80, 8'h81, 8'h7F));
    send_block(make_block(8'h7F, 8'h7F, 8'h7F, 8'h7F, 8'h01, 8'hFE));
    send_block(make_block(8'h04, 8'h08, 8'h07, 8'h03, 8'h83, 8'h7D));
    send_block(make_block(8'hF8, 8'hFC, 8'hFB, 8'hF7, 8'h7D, 8'h83));
    send_block(make_block(8'hAA, 8'h55, 8'h55, 8'hAA, 8'hA5, 8'h5A));
    send_block(make_block(8'h55, 8'hAA, 8'hAA, 8'h55, 8'h5A, 8'hA5));
    send_block(make_block(8'h20, 8'hE0, 8'h60, 8'hA0, 8'h10, 8'hF0));
    drain();

    run_phase(0, 0);
    run_phase(59, 0);
    run_phase(0, 59);
    run_phase(32, 32);

    repeat (10) @(posedge clk);
    if (failures == 0 && pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/y2r565_pkg.sv
rtl/y2r565_chroma.sv
rtl/y2r565_lane.sv
rtl/yuv420_to_rgb565_block_converter.sv
tb/rgb565_pair_checker.sv
tb/yuv420_to_rgb565_block_converter_test.sv
